// File: design/fba_pkg.sv
package fba_pkg;

  // fixed field widths of the item, result and configuration ports
  localparam int SLOT_W     = 3;
  localparam int SIZE_W     = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POLICY      = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLOCK_COUNT = 2'd1;

  // policy codes
  localparam logic POLICY_FIRST_FIT = 1'b0;
  localparam logic POLICY_BEST_FIT  = 1'b1;

  // item modes
  localparam logic MODE_LOAD    = 1'b0;
  localparam logic MODE_REQUEST = 1'b1;

  localparam logic [CFG_DATA_W-1:0] BLOCK_COUNT_RESET = 4'd8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clear;
    logic check;
    logic prefer_small;
  } scan_ctl_t;

endpackage

// File: design/fba_mem.sv
module fba_mem #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 16,
  parameter int AW    = 3
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

// File: design/fba_scan.sv
module fba_scan #(
  parameter int SIZE_BITS = 16,
  parameter int IDX_W     = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  fba_pkg::scan_ctl_t    ctl,
  input  logic [SIZE_BITS-1:0]  entry,
  input  logic [IDX_W-1:0]      entry_idx,
  input  logic [fba_pkg::SIZE_W-1:0] req_size,
  output logic                  found,
  output logic [IDX_W-1:0]      pick_idx,
  output logic [SIZE_BITS-1:0]  best_val
);
  import fba_pkg::*;

  localparam int CMP_W = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;

  logic fits;
  logic take;

  // entry qualifies when it holds at least the full request
  assign fits = CMP_W'(entry) >= CMP_W'(req_size);
  // first fit keeps the first hit, best fit keeps the strictly smaller one
  assign take = fits && (!found || (ctl.prefer_small && (entry < best_val)));

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
    end else if (ctl.check && take) begin
      found <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.check && take) begin
      pick_idx <= entry_idx;
      best_val <= entry;
    end
  end

endmodule

// File: design/fit_block_allocator.sv
// load item: result goes through ST_DONE into the output register once that register is free
// request item: the scan reads one table entry per cycle from the memory, block_count entries
//   (clipped to NUM_BLOCKS), then ST_UPDATE writes back the chosen block, if any
// one item at a time; the next item can go in once the result is registered,
//   even while that result waits in the output register
// rst (synchronous) clears sequencer, scan flags, output valid and config; table undefined
module fit_block_allocator #(
  parameter int NUM_BLOCKS = 8,
  parameter int SIZE_BITS  = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  // item channel
  input  logic                           req_valid,
  output logic                           req_stall,
  input  logic                           mode,
  input  logic [fba_pkg::SLOT_W-1:0]     slot,
  input  logic [fba_pkg::SIZE_W-1:0]     size,
  input  logic                           last_request,
  // result channel
  output logic                           res_valid,
  input  logic                           res_stall,
  output logic                           granted,
  output logic [fba_pkg::SLOT_W-1:0]     block_number,
  output logic [fba_pkg::SIZE_W-1:0]     remaining,
  output logic                           batch_end,
  // configuration write channel
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [fba_pkg::CFG_DATA_W-1:0] cfg_data
);
  import fba_pkg::*;

  localparam int IDX_W = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
  localparam int CNT_W = $clog2(NUM_BLOCKS + 1);
  localparam int CMP_W = (SIZE_BITS > SIZE_W) ? SIZE_BITS : SIZE_W;

  state_t state, state_next;

  // configuration registers
  logic                  policy;
  logic [CFG_DATA_W-1:0] block_count;

  // item registers
  logic [SIZE_W-1:0]     req_size;

  // scan pipeline: address issue, then compare in the following cycle
  logic [CNT_W-1:0]      rd_idx;
  logic                  chk_valid;
  logic [IDX_W-1:0]      chk_idx;
  logic [CNT_W-1:0]      count_lim;
  logic                  issue;

  // pending result, moved to the output register in ST_DONE
  logic                  pend_granted;
  logic [SLOT_W-1:0]     pend_number;
  logic [SIZE_W-1:0]     pend_remaining;
  logic                  pend_last;

  logic                  accept;
  logic                  slot_ok;
  logic                  load_out;

  // memory port signals
  logic                  mem_we;
  logic [IDX_W-1:0]      mem_waddr;
  logic [SIZE_BITS-1:0]  mem_wdata;
  logic [SIZE_BITS-1:0]  mem_rdata;

  // scan unit
  scan_ctl_t             scan_ctl;
  logic                  found;
  logic [IDX_W-1:0]      pick_idx;
  logic [SIZE_BITS-1:0]  best_val;
  logic [SIZE_BITS-1:0]  new_val;

  assign cfg_ready = 1'b1;

  // entries in use, clipped to the table depth
  assign count_lim = (7'(block_count) > 7'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS)
                                                       : CNT_W'(block_count);
  assign slot_ok   = 7'(slot) < 7'(NUM_BLOCKS);
  assign issue     = (state == ST_SCAN) && (rd_idx < count_lim);

  // chosen block shrinks by the request; it is known to fit
  assign new_val = SIZE_BITS'(CMP_W'(best_val) - CMP_W'(req_size));

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    req_stall  = 1'b1;
    accept     = 1'b0;
    load_out   = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = IDX_W'(slot);
    mem_wdata  = SIZE_BITS'(size);
    unique case (state)
      ST_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          accept = 1'b1;
          // a load writes the table right away; out-of-table slots are dropped
          mem_we = (mode == MODE_LOAD) && slot_ok;
          state_next = (mode == MODE_LOAD) ? ST_DONE : ST_SCAN;
        end
      end
      ST_SCAN: begin
        // done once every entry is issued and the last compare has landed
        if (!issue && !chk_valid) begin
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        mem_we     = found;
        mem_waddr  = pick_idx;
        mem_wdata  = new_val;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hand over once the output register is free or being emptied
        if (!res_valid || !res_stall) begin
          load_out   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      policy      <= POLICY_FIRST_FIT;
      block_count <= BLOCK_COUNT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_POLICY:      policy      <= cfg_data[0];
        REG_BLOCK_COUNT: block_count <= cfg_data;
        default: ;
      endcase
    end
  end

  // scan address and compare stage
  always_ff @(posedge clk) begin
    if (rst) begin
      chk_valid <= 1'b0;
    end else if (accept) begin
      chk_valid <= 1'b0;
    end else begin
      chk_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_idx <= '0;
    end else if (issue) begin
      rd_idx <= rd_idx + CNT_W'(1);
    end
    chk_idx <= rd_idx[IDX_W-1:0];
  end

  // pending result: set at accept as load report or refusal, grant overrides
  always_ff @(posedge clk) begin
    if (accept) begin
      req_size       <= size;
      pend_last      <= last_request;
      pend_granted   <= 1'b0;
      pend_number    <= (mode == MODE_LOAD) ? slot : '0;
      pend_remaining <= ((mode == MODE_LOAD) && slot_ok) ? SIZE_W'(SIZE_BITS'(size)) : '0;
    end else if ((state == ST_UPDATE) && found) begin
      pend_granted   <= 1'b1;
      pend_number    <= SLOT_W'(pick_idx);
      pend_remaining <= SIZE_W'(new_val);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_out) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      granted      <= pend_granted;
      block_number <= pend_number;
      remaining    <= pend_remaining;
      batch_end    <= pend_last;
    end
  end

  assign scan_ctl.clear        = accept;
  assign scan_ctl.check        = chk_valid;
  assign scan_ctl.prefer_small = (policy == POLICY_BEST_FIT);

  fba_mem #(
    .DEPTH (NUM_BLOCKS),
    .WIDTH (SIZE_BITS),
    .AW    (IDX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (rd_idx[IDX_W-1:0]),
    .rdata (mem_rdata)
  );

  fba_scan #(
    .SIZE_BITS (SIZE_BITS),
    .IDX_W     (IDX_W)
  ) u_scan (
    .clk       (clk),
    .rst       (rst),
    .ctl       (scan_ctl),
    .entry     (mem_rdata),
    .entry_idx (chk_idx),
    .req_size  (req_size),
    .found     (found),
    .pick_idx  (pick_idx),
    .best_val  (best_val)
  );

endmodule

// File: design/fba_checker.sv
module fba_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           req_valid,
  input logic                           req_stall,
  input logic                           mode,
  input logic [fba_pkg::SLOT_W-1:0]     slot,
  input logic [fba_pkg::SIZE_W-1:0]     size,
  input logic                           last_request,
  input logic                           res_valid,
  input logic                           res_stall,
  input logic                           granted,
  input logic [fba_pkg::SLOT_W-1:0]     block_number,
  input logic [fba_pkg::SIZE_W-1:0]     remaining,
  input logic                           batch_end,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [fba_pkg::CFG_IDX_W-1:0]  cfg_index,
  input logic [fba_pkg::CFG_DATA_W-1:0] cfg_data
);

  // a stalled result holds
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(granted) &&
      $stable(block_number) && $stable(remaining) && $stable(batch_end))
    else $error("stalled result changed");

  // one item at a time: busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("item accepted while busy");

  // no result can appear in the cycle right after an accept
  a_no_early_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> !$rose(res_valid))
    else $error("result too early");

  // a fresh result only follows a busy cycle
  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result without work");

endmodule

bind fit_block_allocator fba_checker u_fba_checker (.*);

// File: test/fit_block_allocator_test.sv
module fit_block_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;

  import fba_pkg::*;

  localparam int TABLE_SLOTS   = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int HOLD_CYCLES   = 300;
  localparam int PHASE_ITEMS   = 60;
  localparam int PHASE_COUNT   = 8;
  localparam int SETTLE_CYCLES = 20;

  // one item on the request channel
  typedef struct packed {
    logic              mode;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] size;
    logic              last;
  } alloc_item_t;

  // one item on the result channel
  typedef struct packed {
    logic              granted;
    logic [SLOT_W-1:0] number;
    logic [SIZE_W-1:0] kb_left;
    logic              batch_end;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic                  mode = MODE_LOAD;
  logic [SLOT_W-1:0]     slot = '0;
  logic [SIZE_W-1:0]     size = '0;
  logic                  last_request = 1'b0;
  logic                  res_valid;
  logic                  res_stall = 1'b0;
  logic                  granted;
  logic [SLOT_W-1:0]     block_number;
  logic [SIZE_W-1:0]     remaining;
  logic                  batch_end;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // predictor state: free size per table entry plus the register copies
  logic [SIZE_W-1:0]     free_kb [TABLE_SLOTS];
  logic                  cur_policy = POLICY_FIRST_FIT;
  logic [CFG_DATA_W-1:0] cur_count = BLOCK_COUNT_RESET;

  alloc_item_t pending_items [$];
  grant_t      expected_grants [$];
  int          items_queued = 0;
  int          items_taken = 0;
  int          mismatches = 0;
  bit          item_taken = 1'b0;

  // idling control: quiet is shared by both sides, the hold counters serve the receiver
  bit          quiet = 1'b0;
  int          hold_asked = 0;
  int          hold_done = 0;
  int          hold_left = 0;
  int          watch_cycles;

  fit_block_allocator #(
    .NUM_BLOCKS(TABLE_SLOTS),
    .SIZE_BITS (SIZE_W)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .mode        (mode),
    .slot        (slot),
    .size        (size),
    .last_request(last_request),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .granted     (granted),
    .block_number(block_number),
    .remaining   (remaining),
    .batch_end   (batch_end),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  always #5 clk = ~clk;

  // expected outcome of one item; updates the predicted table
  function automatic grant_t predict_allocation(input alloc_item_t it);
    grant_t r;
    int     span;
    int     pick;
    r = '0;
    r.batch_end = it.last;
    if (it.mode == MODE_LOAD) begin
      // slot is 3 bits wide, so every load lands inside the table
      free_kb[it.slot] = it.size;
      r.number = it.slot;
      r.kb_left = it.size;
    end else begin
      // counts above the table size search the whole table, zero searches nothing
      span = (cur_count > TABLE_SLOTS) ? TABLE_SLOTS : int'(cur_count);
      pick = -1;
      for (int j = 0; j < span; j++) begin
        if (free_kb[j] >= it.size) begin
          if (pick < 0) begin
            pick = j;
            if (cur_policy == POLICY_FIRST_FIT) break;
          end else if (free_kb[j] < free_kb[pick]) begin
            // best fit only; strict compare keeps the lowest index on a tie
            pick = j;
          end
        end
      end
      if (pick >= 0) begin
        free_kb[pick] = free_kb[pick] - it.size;
        r.granted = 1'b1;
        r.number = 3'(pick);
        r.kb_left = free_kb[pick];
      end
    end
    return r;
  endfunction

  task automatic check_field(input string name, input logic [SIZE_W-1:0] want,
                             input logic [SIZE_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endtask

  task automatic queue_item(input logic md, input logic [SLOT_W-1:0] sl,
                            input logic [SIZE_W-1:0] sz, input logic lst);
    pending_items.push_back('{md, sl, sz, lst});
    items_queued++;
  endtask

  // wait until every queued item went in and every result came back
  task automatic drain();
    while (items_taken < items_queued || expected_grants.size() != 0)
      @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    if (idx == REG_POLICY) cur_policy = val[0];
    else if (idx == REG_BLOCK_COUNT) cur_count = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // request driver: holds an item until taken, idles at random otherwise
  always @(negedge clk) begin
    alloc_item_t nxt;
    if (rst) begin
      req_valid <= 1'b0;
    end else if (!req_valid || item_taken) begin
      if (pending_items.size() > 0 && (quiet || $urandom_range(0, 99) >= 18)) begin
        nxt = pending_items.pop_front();
        req_valid    <= 1'b1;
        mode         <= nxt.mode;
        slot         <= nxt.slot;
        size         <= nxt.size;
        last_request <= nxt.last;
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // result receiver: random stalls, plus a long hold-off when asked
  always @(negedge clk) begin
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left--;
    end else if (hold_asked != hold_done) begin
      hold_done = hold_asked;
      hold_left = HOLD_CYCLES;
      res_stall <= 1'b1;
    end else begin
      res_stall <= !quiet && ($urandom_range(0, 99) < 18);
    end
  end

  // monitor: check results first, then predict for an item taken on this edge
  always @(posedge clk) begin
    grant_t got;
    grant_t want;
    item_taken = 1'b0;
    if (!rst) begin
      if (res_valid === 1'b1 && !res_stall) begin
        got = '{granted, block_number, remaining, batch_end};
        if (expected_grants.size() == 0) begin
          $error("result item with nothing expected: %p", got);
          mismatches++;
        end else begin
          want = expected_grants.pop_front();
          check_field("granted", SIZE_W'(want.granted), SIZE_W'(got.granted));
          check_field("block_number", SIZE_W'(want.number), SIZE_W'(got.number));
          check_field("remaining", want.kb_left, got.kb_left);
          check_field("batch_end", SIZE_W'(want.batch_end), SIZE_W'(got.batch_end));
        end
      end
      if (req_valid && req_stall === 1'b0) begin
        item_taken = 1'b1;
        expected_grants.push_back(predict_allocation('{mode, slot, size, last_request}));
        items_taken++;
      end
    end
  end

  // watchdog
  initial begin
    for (watch_cycles = 0; watch_cycles < CYCLE_LIMIT; watch_cycles++)
      @(posedge clk);
    $display("fit_block_allocator: mismatch");
    $finish;
  end

  initial begin
    logic                  plan_policy [PHASE_COUNT];
    logic [CFG_DATA_W-1:0] plan_count [PHASE_COUNT];
    logic                  md;
    logic [SIZE_W-1:0]     sz;
    int                    pick;
    // register settings per random phase, extremes of the count included
    plan_policy = '{POLICY_FIRST_FIT, POLICY_BEST_FIT, POLICY_FIRST_FIT, POLICY_BEST_FIT,
                    POLICY_FIRST_FIT, POLICY_BEST_FIT, POLICY_FIRST_FIT, POLICY_BEST_FIT};
    plan_count  = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd9, 4'd5, 4'd3, 4'd8};

    for (int i = 0; i < TABLE_SLOTS; i++) free_kb[i] = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the whole table first so no request reads an unloaded entry
    queue_item(MODE_LOAD, 3'd0, 16'hffff, 1'b0);
    queue_item(MODE_LOAD, 3'd1, 16'h0000, 1'b0);
    queue_item(MODE_LOAD, 3'd2, 16'd100, 1'b0);
    queue_item(MODE_LOAD, 3'd3, 16'd50, 1'b0);
    queue_item(MODE_LOAD, 3'd4, 16'd100, 1'b0);
    queue_item(MODE_LOAD, 3'd5, 16'h8000, 1'b0);
    queue_item(MODE_LOAD, 3'd6, 16'h7fff, 1'b0);
    queue_item(MODE_LOAD, 3'd7, 16'd1, 1'b1);
    // first fit at reset settings
    queue_item(MODE_REQUEST, 3'd7, 16'h0000, 1'b0);  // zero size, block unchanged
    queue_item(MODE_REQUEST, 3'd0, 16'hffff, 1'b0);  // empties block 0
    queue_item(MODE_REQUEST, 3'd5, 16'hffff, 1'b0);  // nothing fits, refused
    queue_item(MODE_REQUEST, 3'd0, 16'd60, 1'b0);
    queue_item(MODE_REQUEST, 3'd2, 16'd1, 1'b1);
    drain();
    repeat (4) @(posedge clk);

    // best fit: exact fit, smallest fit, tie between equal blocks, refusal
    write_reg(REG_POLICY, POLICY_BEST_FIT);
    queue_item(MODE_REQUEST, 3'd0, 16'd50, 1'b0);
    queue_item(MODE_REQUEST, 3'd0, 16'd30, 1'b0);
    queue_item(MODE_LOAD, 3'd2, 16'd100, 1'b0);
    queue_item(MODE_REQUEST, 3'd3, 16'd100, 1'b0);
    queue_item(MODE_REQUEST, 3'd1, 16'h0000, 1'b0);
    queue_item(MODE_REQUEST, 3'd6, 16'h8001, 1'b1);

    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      drain();
      repeat (4) @(posedge clk);
      write_reg(REG_POLICY, plan_policy[ph]);
      write_reg(REG_BLOCK_COUNT, plan_count[ph]);
      // one phase runs without any idling on either side
      quiet = (ph == 2);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        // mostly requests, with enough reloads to keep blocks worth asking for
        md = ($urandom_range(0, 99) < 30) ? MODE_LOAD : MODE_REQUEST;
        pick = $urandom_range(0, 99);
        if (md == MODE_LOAD) begin
          if (pick < 70) sz = 16'($urandom_range(0, 2000));
          else if (pick < 90) sz = 16'($urandom_range(0, 65535));
          else sz = (pick < 95) ? 16'h0000 : 16'hffff;
        end else begin
          if (pick < 60) sz = 16'($urandom_range(0, 400));
          else if (pick < 75) sz = 16'h0000;
          else if (pick < 90) sz = 16'($urandom_range(0, 65535));
          else sz = 16'($urandom_range(1000, 2000));
        end
        queue_item(md, 3'($urandom_range(0, 7)), sz, $urandom_range(0, 3) == 0);
      end
      // long receiver hold-off while the sender keeps offering items
      if (ph == 4) hold_asked++;
    end

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("fit_block_allocator: match");
    end else begin
      $display("fit_block_allocator: mismatch");
    end
    $finish;
  end

endmodule
